// ===== rtl/olsn_pkg.sv =====
// olsn_pkg: types and constants shared by the ordered list store
// used by olsn_cell, olsn_chain and ordered_list_store_with_neighbours_top
`timescale 1ns / 1ps

package olsn_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int POS_W         = 7;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cmd_type                   command;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          length;
      logic signed [DATA_W-1:0]  read_value;
      logic [POS_W-1:0]          found_position;
      logic                      has_prev;
      logic signed [DATA_W-1:0]  prev_value;
      logic                      has_next;
      logic signed [DATA_W-1:0]  next_value;
   } rsp_payload_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [DATA_W-1:0]  value;
   } cell_ctl_type;

endpackage

// ===== rtl/olsn_cell.sv =====
// olsn_cell: one storage cell of the list, takes its neighbor's entry on a shift
// depends on olsn_pkg
`timescale 1ns / 1ps

module olsn_cell #(
   parameter int DEPTH = olsn_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  olsn_pkg::cell_ctl_type               ctl,
   input  logic [$clog2(DEPTH)-1:0]             idx,
   input  logic signed [olsn_pkg::DATA_W-1:0]   left_data,
   input  logic signed [olsn_pkg::DATA_W-1:0]   right_data,
   output logic signed [olsn_pkg::DATA_W-1:0]   data
);
   import olsn_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INSERT: begin
            // cells above the slot move up, the slot takes the new value
            if (MY_IDX > idx) begin
               data_in = left_data;
            end else if (MY_IDX == idx) begin
               data_in = ctl.value;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= idx) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/olsn_chain.sv =====
// olsn_chain: ring of DEPTH cells, head entry visible at cell zero
// depends on olsn_pkg and olsn_cell
`timescale 1ns / 1ps

module olsn_chain #(
   parameter int DEPTH = olsn_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  olsn_pkg::cell_ctl_type               ctl,
   input  logic [$clog2(DEPTH)-1:0]             idx,
   output logic signed [olsn_pkg::DATA_W-1:0]   head
);
   import olsn_pkg::*;

   logic signed [DATA_W-1:0] cells [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_w;
      logic signed [DATA_W-1:0] right_w;

      // cell zero never moves up on insert; the last cell wraps for rotation
      if (i == 0) begin : g_first
         assign left_w = cells[0];
      end else begin : g_mid_l
         assign left_w = cells[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = cells[0];
      end else begin : g_mid_r
         assign right_w = cells[i+1];
      end

      olsn_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (idx),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cells[i])
      );
   end

   assign head = cells[0];

endmodule

// ===== rtl/ordered_list_store_with_neighbours_top.sv =====
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_payload (command, position, value)
// rsp     | out       | rsp_valid / rsp_ready | rsp_payload (status, length, get and find fields)
//
// insert, delete and range or full errors: accept, then load of the result register once rsp is free.
// get and find: accept, then a scan in which the cell ring rotates one place per cycle past
// cell zero and is back in order after DEPTH shifts, then load of the result register.
// reset clears the entry count and control only; cells hold no reset value.
// a new item is taken while the previous result still waits in the result register;
// a stalled rsp channel holds the finished item in the working register until free.
// depends on olsn_pkg and olsn_chain
`timescale 1ns / 1ps

module ordered_list_store_with_neighbours_top #(
   parameter int DEPTH = olsn_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  olsn_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output olsn_pkg::rsp_payload_type  rsp_payload
);
   import olsn_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             step_ff, step_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [IW-1:0]             k_ff, k_in;
   logic signed [DATA_W-1:0]  key_ff, key_in;
   logic signed [DATA_W-1:0]  prev_ff, prev_in;
   logic                      found_ff, found_in;
   logic                      want_ff, want_in;
   rsp_payload_type           res_ff, res_in;
   rsp_payload_type           rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   cell_ctl_type              ctl;
   logic [IW-1:0]             cell_idx;
   logic signed [DATA_W-1:0]  head;

   logic [CMPW-1:0]           pos_ext;
   logic [CMPW-1:0]           cnt_ext;
   logic                      in_range;

   olsn_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock (clock),
      .ctl   (ctl),
      .idx   (cell_idx),
      .head  (head)
   );

   assign pos_ext   = CMPW'(req_payload.position);
   assign cnt_ext   = CMPW'(count_ff);
   assign in_range  = step_ff < count_ff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      want_in      = want_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.op       = CELL_HOLD;
      ctl.value    = req_payload.value;
      cell_idx     = IW'(pos_ext - CMPW'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in        = '0;
               res_in.status = ST_OK;
               cmd_in        = req_payload.command;
               key_in        = req_payload.value;
               k_in          = IW'(pos_ext - CMPW'(1));
               step_in       = '0;
               found_in      = 1'b0;
               want_in       = 1'b0;
               prev_in       = '0;
               state_in      = S_DONE;
               unique case (req_payload.command)
                  CMD_INSERT: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                        res_in.status = ST_RANGE;
                     end else if (count_ff == CW'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        ctl.op   = CELL_DELETE;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_GET: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FIND: begin
                     res_in.status = ST_NOTFOUND;
                     state_in      = S_SCAN;
                  end
                  default: begin
                     res_in.status = ST_RANGE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // head shows entry step_ff; the ring is back in place after DEPTH shifts
            ctl.op  = CELL_ROTATE;
            prev_in = head;
            step_in = step_ff + CW'(1);
            if (cmd_ff == CMD_GET) begin
               if (step_ff == CW'(k_ff)) begin
                  res_in.read_value = head;
               end
            end else begin
               if (want_ff) begin
                  want_in           = 1'b0;
                  res_in.has_next   = in_range;
                  res_in.next_value = in_range ? head : '0;
               end
               if (!found_ff && in_range && head == key_ff) begin
                  found_in              = 1'b1;
                  want_in               = 1'b1;
                  res_in.status         = ST_OK;
                  res_in.found_position = POS_W'(step_ff + CW'(1));
                  res_in.has_prev       = (step_ff != '0);
                  res_in.prev_value     = (step_ff != '0) ? prev_ff : '0;
               end
            end
            if (step_ff == CW'(DEPTH - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in        = res_ff;
               rsp_in.length = POS_W'(count_ff);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         want_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         want_ff      <= want_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      cmd_ff  <= cmd_in;
      k_ff    <= k_in;
      key_ff  <= key_in;
      prev_ff <= prev_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> $past(req_valid && req_ready))
      else $error("entry count changed without an accepted item");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.found_position == '0 || rsp_ff.status == ST_OK))
      else $error("found position reported with error status");

   a_prev_not_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.has_prev) |-> (rsp_ff.found_position > POS_W'(1)))
      else $error("first entry reported with a predecessor");

endmodule
